// ===== sv/aft_pkg.sv =====
// shared types and constants for the animation frame timeline
// no dependencies; used by every module of the block by scoped names

package aft_pkg;

    // field and register widths
    localparam int DELTA_W    = 32;
    localparam int DUR_W      = 16;
    localparam int FRAME_W    = 8;
    localparam int COUNT_W    = 7;
    localparam int RUN_IDX_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // datapath widths
    localparam int PERIOD_W = 21;               // period and elapsed time in ms
    localparam int REM_W    = PERIOD_W + 1;     // shifted partial remainder
    localparam int SUM_W    = 33;               // elapsed plus delta
    localparam int TICK_W   = 17;               // tick of a wrapped time
    localparam int Y_W      = 22;               // duration * 50 + 2
    localparam int Z_W      = 22;               // elapsed * 3
    localparam int ENTRY_W  = DUR_W + FRAME_W;  // one run table word

    // ceil(duration * 1000 / 60) = (duration * 50 + 2) / 3, done by reciprocal
    localparam logic [Y_W-1:0] CEIL_BIAS   = 22'd2;
    localparam int             DIV3_MUL_W  = 24;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 24'd11184811;
    localparam int             DIV3_SHIFT  = 25;
    localparam logic [PERIOD_W-1:0] HOLD_MS = 21'd2000;

    // tick = elapsed * 60 / 1000 = (elapsed * 3) / 50, done by reciprocal
    localparam int              DIV50_MUL_W = 23;
    localparam logic [DIV50_MUL_W-1:0] DIV50_MUL = 23'd5368710;
    localparam int              DIV50_SHIFT = 28;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANIM_VALID = 2'd0,
        CFG_RUN_COUNT  = 2'd1,
        CFG_DURATION   = 2'd2
    } cfg_index_t;

    // item kinds
    typedef enum logic {
        ACT_ADVANCE = 1'b0,
        ACT_LOAD    = 1'b1
    } action_t;

    // controls broadcast to every remainder cell
    typedef struct packed {
        logic clr;   // clear the stored bit
        logic step;  // do one restoring step
        logic take;  // the trial subtraction did not borrow
    } cell_ctrl_t;

endpackage

// ===== sv/aft_rem_cell.sv =====
// one bit slice of the restoring remainder chain
// depends on aft_pkg for the control struct

module aft_rem_cell (
    input  logic                clk,
    input  aft_pkg::cell_ctrl_t ctrl,
    input  logic                shift_in,
    input  logic                div_bit,
    input  logic                borrow_in,
    output logic                rem_bit,
    output logic                borrow_out
);

    logic rem_reg;
    logic rem_next;
    logic diff_bit;

    // trial subtraction slice, borrow ripples to the upper neighbor
    assign diff_bit   = shift_in ^ div_bit ^ borrow_in;
    assign borrow_out = (~shift_in & div_bit) | (~(shift_in ^ div_bit) & borrow_in);

    // keep the difference or the shifted bit
    always_comb
    begin
        rem_next = rem_reg;
        if (ctrl.clr)
        begin
            rem_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            rem_next = ctrl.take ? diff_bit : shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign rem_bit = rem_reg;

endmodule

// ===== sv/aft_divider.sv =====
// serial remainder unit: a chain of bit cells, one dividend bit per cycle
// depends on aft_pkg and aft_rem_cell

module aft_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [aft_pkg::SUM_W-1:0]     dividend,
    input  logic [aft_pkg::PERIOD_W-1:0]  divisor,
    output logic                          busy,
    output logic [aft_pkg::PERIOD_W-1:0]  rem
);

    localparam int CNT_W = $clog2(aft_pkg::SUM_W + 1);

    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic [aft_pkg::SUM_W-1:0]     dvd_reg;
    logic [aft_pkg::SUM_W-1:0]     dvd_next;
    logic [aft_pkg::REM_W-1:0]     rem_bits;
    logic [aft_pkg::REM_W-1:0]     div_ext;
    logic [aft_pkg::REM_W:0]       borrow;
    aft_pkg::cell_ctrl_t           ctrl;

    assign div_ext   = {1'b0, divisor};
    assign borrow[0] = 1'b0;

    // broadcast controls
    always_comb
    begin
        ctrl.clr  = start;
        ctrl.step = busy_reg;
        ctrl.take = ~borrow[aft_pkg::REM_W];
    end

    // row of remainder cells, the dividend enters at the bottom
    for (genvar i = 0; i < aft_pkg::REM_W; i++)
    begin : g_cell
        logic sin;
        if (i == 0)
        begin : g_first
            assign sin = dvd_reg[aft_pkg::SUM_W-1];
        end
        else
        begin : g_rest
            assign sin = rem_bits[i-1];
        end
        aft_rem_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .shift_in   (sin),
            .div_bit    (div_ext[i]),
            .borrow_in  (borrow[i]),
            .rem_bit    (rem_bits[i]),
            .borrow_out (borrow[i+1])
        );
    end

    // step counter and dividend shifter
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        dvd_next  = dvd_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(aft_pkg::SUM_W);
            busy_next = 1'b1;
            dvd_next  = dividend;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[aft_pkg::SUM_W-2:0], 1'b0};
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_bits[aft_pkg::PERIOD_W-1:0];

endmodule

// ===== sv/aft_run_table.sv =====
// run table memory: end tick and frame per entry, registered read
// depends on aft_pkg for the entry width

module aft_run_table #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [aft_pkg::ENTRY_W-1:0] wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [aft_pkg::ENTRY_W-1:0] rdata
);

    logic [aft_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [aft_pkg::ENTRY_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/animation_frame_timeline.sv =====
// top level of the animation frame timeline
// depends on aft_pkg, aft_divider (with aft_rem_cell) and aft_run_table

// One item at a time. A load item, or an advance while no animation is
// loaded, goes straight to the done state and puts its result in the
// output register once that register is free. An advance first forms the
// period, then wraps the elapsed time in the serial remainder chain (one
// dividend bit per cycle over 33 bits), converts it to a tick, checks the
// hold and registers the result. When the tick is below the duration, a
// binary search comes before the result: each probe reads the run table's
// registered read port and then compares (up to seven probes for 64 runs),
// a last search step closes it, and one read fetches the chosen frame when
// a run covers the tick. The next item can be taken from the cycle in which
// a result sits in the output register, whether or not it has been taken
// yet; a result that cannot enter the output register holds its item until
// the register frees up. There is no clearing pass; run entries read before
// they are written return garbage.
module animation_frame_timeline #(
    parameter int MAX_RUNS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input items
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [aft_pkg::DELTA_W-1:0]       advance_ms,
    input  logic [aft_pkg::RUN_IDX_W-1:0]     run_index,
    input  logic [aft_pkg::DUR_W-1:0]         run_end_tick,
    input  logic [aft_pkg::FRAME_W-1:0]       run_frame,
    // results
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [aft_pkg::FRAME_W-1:0]       frame,
    output logic                              changed,
    output logic                              holding,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [aft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aft_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CNT_W  = $clog2(MAX_RUNS + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PER   = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_TICK  = 9'b000001000,
        S_SETUP = 9'b000010000,
        S_SRCH  = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_FRM   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t                             state_reg, state_next;
    logic                               anim_valid_reg, anim_valid_next;
    logic [aft_pkg::COUNT_W-1:0]        run_count_reg, run_count_next;
    logic [aft_pkg::DUR_W-1:0]          duration_reg, duration_next;
    logic [aft_pkg::PERIOD_W-1:0]       elapsed_reg, elapsed_next;
    logic [aft_pkg::FRAME_W-1:0]        cur_frame_reg, cur_frame_next;
    logic [aft_pkg::Y_W-1:0]            y_reg, y_next;
    logic [aft_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [aft_pkg::PERIOD_W-1:0]       period_reg, period_next;
    logic [aft_pkg::Z_W-1:0]            z_reg, z_next;
    logic [aft_pkg::TICK_W-1:0]         tick_reg, tick_next;
    logic [CNT_W-1:0]                   lo_reg, lo_next;
    logic [CNT_W-1:0]                   hi_reg, hi_next;
    logic [CNT_W-1:0]                   mid_reg, mid_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [aft_pkg::FRAME_W-1:0]        next_frame_reg, next_frame_next;
    logic                               holding_reg, holding_next;
    logic                               out_valid_reg, out_valid_next;
    logic [aft_pkg::FRAME_W-1:0]        out_frame_reg, out_frame_next;
    logic                               out_changed_reg, out_changed_next;
    logic                               out_holding_reg, out_holding_next;

    logic                               in_xfer;
    logic                               div_start;
    logic                               div_busy;
    logic [aft_pkg::PERIOD_W-1:0]       div_rem;
    logic                               tbl_we;
    logic [ADDR_W-1:0]                  tbl_waddr;
    logic                               tbl_re;
    logic [ADDR_W-1:0]                  tbl_raddr;
    logic [aft_pkg::ENTRY_W-1:0]        tbl_rdata;
    logic [aft_pkg::DUR_W-1:0]          rd_end;
    logic [CNT_W-1:0]                   mid;
    logic [CNT_W-1:0]                   count_sat;
    logic [aft_pkg::Y_W+aft_pkg::DIV3_MUL_W-1:0]  per_prod;
    logic [aft_pkg::Z_W+aft_pkg::DIV50_MUL_W-1:0] tick_prod;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // reciprocal multipliers for the two constant divisions
    assign per_prod  = (aft_pkg::Y_W+aft_pkg::DIV3_MUL_W)'(y_reg)
                       * (aft_pkg::Y_W+aft_pkg::DIV3_MUL_W)'(aft_pkg::DIV3_MUL);
    assign tick_prod = (aft_pkg::Z_W+aft_pkg::DIV50_MUL_W)'(z_reg)
                       * (aft_pkg::Z_W+aft_pkg::DIV50_MUL_W)'(aft_pkg::DIV50_MUL);

    // run count saturated to the table depth
    assign count_sat = (32'(run_count_reg) > MAX_RUNS) ? CNT_W'(MAX_RUNS)
                                                       : CNT_W'(run_count_reg);

    // search probe point and table word split
    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_end = tbl_rdata[aft_pkg::ENTRY_W-1:aft_pkg::FRAME_W];

    // table write on a load transfer inside the table
    assign tbl_we    = in_xfer && (action == aft_pkg::ACT_LOAD)
                       && (32'(run_index) < MAX_RUNS);
    assign tbl_waddr = ADDR_W'(run_index);
    assign tbl_re    = (state_reg == S_SRCH);
    assign tbl_raddr = (lo_reg < hi_reg) ? mid[ADDR_W-1:0] : lo_reg[ADDR_W-1:0];

    assign div_start = (state_reg == S_PER);

    // configuration writes
    always_comb
    begin
        anim_valid_next = anim_valid_reg;
        run_count_next  = run_count_reg;
        duration_next   = duration_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                aft_pkg::CFG_ANIM_VALID: anim_valid_next = cfg_data[0];
                aft_pkg::CFG_RUN_COUNT:  run_count_next  = cfg_data[aft_pkg::COUNT_W-1:0];
                aft_pkg::CFG_DURATION:   duration_next   = cfg_data[aft_pkg::DUR_W-1:0];
                default:                 ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        elapsed_next     = elapsed_reg;
        cur_frame_next   = cur_frame_reg;
        y_next           = y_reg;
        sum_next         = sum_reg;
        period_next      = period_reg;
        z_next           = z_reg;
        tick_next        = tick_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        count_next       = count_reg;
        next_frame_next  = next_frame_reg;
        holding_next     = holding_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_frame_next   = out_frame_reg;
        out_changed_next = out_changed_reg;
        out_holding_next = out_holding_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    holding_next    = 1'b0;
                    next_frame_next = cur_frame_reg;
                    y_next   = {duration_reg, 6'b0} - {2'b0, duration_reg, 4'b0}
                               + {5'b0, duration_reg, 1'b0} + aft_pkg::CEIL_BIAS;
                    sum_next = aft_pkg::SUM_W'(elapsed_reg) + aft_pkg::SUM_W'(advance_ms);
                    if ((action == aft_pkg::ACT_ADVANCE) && anim_valid_reg)
                    begin
                        state_next = S_PER;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PER:
            begin
                // period in ms, the remainder chain starts on the same edge
                period_next = aft_pkg::PERIOD_W'(per_prod >> aft_pkg::DIV3_SHIFT)
                              + aft_pkg::HOLD_MS;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    elapsed_next = div_rem;
                    z_next       = {1'b0, div_rem} + {div_rem, 1'b0};
                    state_next   = S_TICK;
                end
            end
            S_TICK:
            begin
                tick_next  = aft_pkg::TICK_W'(tick_prod >> aft_pkg::DIV50_SHIFT);
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                if (tick_reg >= aft_pkg::TICK_W'(duration_reg))
                begin
                    holding_next    = 1'b1;
                    next_frame_next = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = count_sat;
                    count_next = count_sat;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid;
                    state_next = S_CMP;
                end
                else if (lo_reg >= count_reg)
                begin
                    next_frame_next = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_FRM;
                end
            end
            S_CMP:
            begin
                if (tick_reg < aft_pkg::TICK_W'(rd_end))
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + 1'b1;
                end
                state_next = S_SRCH;
            end
            S_FRM:
            begin
                next_frame_next = tbl_rdata[aft_pkg::FRAME_W-1:0];
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                // wait for a free output register
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_frame_next   = next_frame_reg;
                    out_changed_next = (next_frame_reg != cur_frame_reg);
                    out_holding_next = holding_reg;
                    cur_frame_next   = next_frame_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            anim_valid_reg <= 1'b0;
            run_count_reg  <= '0;
            duration_reg   <= '0;
            elapsed_reg    <= '0;
            cur_frame_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            anim_valid_reg <= anim_valid_next;
            run_count_reg  <= run_count_next;
            duration_reg   <= duration_next;
            elapsed_reg    <= elapsed_next;
            cur_frame_reg  <= cur_frame_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        y_reg           <= y_next;
        sum_reg         <= sum_next;
        period_reg      <= period_next;
        z_reg           <= z_next;
        tick_reg        <= tick_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        mid_reg         <= mid_next;
        count_reg       <= count_next;
        next_frame_reg  <= next_frame_next;
        holding_reg     <= holding_next;
        out_frame_reg   <= out_frame_next;
        out_changed_reg <= out_changed_next;
        out_holding_reg <= out_holding_next;
    end

    // elapsed time wrap
    aft_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (period_reg),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    // run entries
    aft_run_table #(
        .DEPTH  (MAX_RUNS),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata ({run_end_tick, run_frame}),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign out_valid = out_valid_reg;
    assign frame     = out_frame_reg;
    assign changed   = out_changed_reg;
    assign holding   = out_holding_reg;

    // an accepted item always leaves idle
    a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    // the remainder chain only runs while the sequencer waits on it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider busy outside its wait state");

    // search window never inverts
    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (lo_reg <= hi_reg))
        else $error("binary search bounds crossed");

    // a hold result always shows frame zero
    a_hold_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && holding) |-> (frame == '0))
        else $error("hold result with a nonzero frame");

endmodule
